@@ rtl/pwt_pkg.sv @@
// Package for the pixelate-with-threshold block: widths, register indexes,
// reset values and shared types. No dependencies.
`default_nettype none

package pwt_pkg;

    localparam int POS_W      = 8;
    localparam int CH_W       = 8;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int PIX_W      = 4 * CH_W;
    localparam int CNT_W      = $clog2(POS_W + 1);

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_WIDTH  = 3'd0,
        REG_BLOCK_HEIGHT = 3'd1,
        REG_FRAME_WIDTH  = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_THR_ENABLE   = 3'd4,
        REG_THR_LEVEL    = 3'd5
    } reg_idx_t;

    localparam logic [SIZE_W-1:0] RST_BLOCK_WIDTH  = 9'd16;
    localparam logic [SIZE_W-1:0] RST_BLOCK_HEIGHT = 9'd16;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic              RST_THR_ENABLE   = 1'b1;
    localparam logic [CH_W-1:0]   RST_THR_LEVEL    = 8'd128;

    typedef struct packed {
        logic              busy;
        logic [SIZE_W-1:0] rem;
    } rem_stat_t;

endpackage

`default_nettype wire

@@ rtl/pwt_if.sv @@
// Channel interfaces: pixel request, result and configuration write.
// Depends on pwt_pkg.
`default_nettype none

interface pwt_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [pwt_pkg::POS_W-1:0]   pos_x;
    logic [pwt_pkg::POS_W-1:0]   pos_y;
    logic [pwt_pkg::CH_W-1:0]    red_in;
    logic [pwt_pkg::CH_W-1:0]    green_in;
    logic [pwt_pkg::CH_W-1:0]    blue_in;
    logic [pwt_pkg::CH_W-1:0]    alpha_in;

    modport source (output valid, func, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
                    input ready);
    modport sink   (input valid, func, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
                    output ready);
endinterface

interface pwt_res_if;
    logic                     valid;
    logic                     ready;
    logic [pwt_pkg::CH_W-1:0] red_out;
    logic [pwt_pkg::CH_W-1:0] green_out;
    logic [pwt_pkg::CH_W-1:0] blue_out;
    logic [pwt_pkg::CH_W-1:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface pwt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pwt_pkg::CFG_IDX_W-1:0]  index;
    logic [pwt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/pwt_rem.sv @@
// Bit-serial restoring remainder unit: pos mod divisor, one bit per cycle.
// Depends on pwt_pkg.
`default_nettype none

module pwt_rem (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pwt_pkg::POS_W-1:0]   pos,
    input  wire logic [pwt_pkg::SIZE_W-1:0]  divisor,
    output pwt_pkg::rem_stat_t               stat
);

    logic [pwt_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [pwt_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [pwt_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic [pwt_pkg::SIZE_W-1:0] div_reg, div_next;
    logic [pwt_pkg::SIZE_W:0]   trial;

    assign trial = {rem_reg, pos_reg[pwt_pkg::POS_W-1]};

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            cnt_next = pwt_pkg::CNT_W'(pwt_pkg::POS_W);
            pos_next = pos;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            pos_next = pos_reg << 1;
            if (trial >= {1'b0, div_reg})
                rem_next = pwt_pkg::SIZE_W'(trial - {1'b0, div_reg});
            else
                rem_next = pwt_pkg::SIZE_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

@@ rtl/pwt_frame_mem.sv @@
// Frame store: one write port, one read port, registered read data.
// Depends on pwt_pkg.
`default_nettype none

module pwt_frame_mem #(
    parameter int DEPTH = pwt_pkg::DEF_MAX_WIDTH * pwt_pkg::DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [pwt_pkg::PIX_W-1:0]  wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic      [pwt_pkg::PIX_W-1:0]  rdata
);

    logic [pwt_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/block_pixelate_with_threshold_unit.sv @@
// Mosaic pixelation with brightness threshold over a frame store.
// Channels:
//   pix  requests: func 0 writes an RGBA pixel at (pos_x, pos_y), func 1
//        asks for the mosaic color at (pos_x, pos_y).
//   res  one result per read request, none per write.
//   cfg  register writes (block size, frame size, threshold), always ready.
// A write is stored as it is accepted; writes outside the store are dropped.
// A read first runs the divide phase: eight bit-serial remainder steps on
// each axis find the block origin, and the sequencer waits in S_DIV until
// the units finish. Then S_ADDR clamps the sample point, S_READ issues the
// store read and S_RESULT thresholds the returned word into the output
// register. The next request is taken once the result has been loaded.
// Reset clears the control state and loads the register defaults; the
// frame store is not cleared and reads undefined until written.
// While res is stalled the result holds; new requests are still taken while
// idle, and a read runs up to its output stage and waits there.
// Depends on pwt_pkg, pwt_if, pwt_rem and pwt_frame_mem.
`default_nettype none

module block_pixelate_with_threshold_unit #(
    parameter int MAX_WIDTH  = pwt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pwt_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pwt_pix_if.sink    pix,
    pwt_res_if.source  res,
    pwt_cfg_if.sink    cfg
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XCW   = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
    localparam int YCW   = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_ADDR   = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [pwt_pkg::SIZE_W-1:0] bw_reg, bh_reg, fw_reg, fh_reg;
    logic                       thr_en_reg;
    logic [pwt_pkg::CH_W-1:0]   thr_lvl_reg;

    logic [pwt_pkg::POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic [XW-1:0]              sx_reg, sx_next;
    logic [YW-1:0]              sy_reg, sy_next;

    logic                       res_valid_reg, res_valid_next;
    logic [pwt_pkg::CH_W-1:0]   red_reg, green_reg, blue_reg, alpha_reg;

    logic                       pix_acc, rd_start, wr_ok, mem_we, load;
    logic [AW-1:0]              waddr, raddr;
    logic [pwt_pkg::PIX_W-1:0]  wdata, rdata;
    pwt_pkg::rem_stat_t         x_stat, y_stat;

    logic [pwt_pkg::SIZE_W-1:0] bw_eff, bh_eff, fw_eff, fh_eff;
    logic [pwt_pkg::POS_W-1:0]  x_org, y_org;
    logic [XCW-1:0]             x_smp, x_fs, x_lim, x_cl;
    logic [YCW-1:0]             y_smp, y_fs, y_lim, y_cl;

    logic [pwt_pkg::CH_W-1:0]   r_s, g_s, b_s, a_s, br_rg, br;
    logic                       dark;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg      <= pwt_pkg::RST_BLOCK_WIDTH;
            bh_reg      <= pwt_pkg::RST_BLOCK_HEIGHT;
            fw_reg      <= pwt_pkg::RST_FRAME_WIDTH;
            fh_reg      <= pwt_pkg::RST_FRAME_HEIGHT;
            thr_en_reg  <= pwt_pkg::RST_THR_ENABLE;
            thr_lvl_reg <= pwt_pkg::RST_THR_LEVEL;
        end
        else if (cfg.valid)
        begin
            case (pwt_pkg::reg_idx_t'(cfg.index))
                pwt_pkg::REG_BLOCK_WIDTH:  bw_reg      <= cfg.data;
                pwt_pkg::REG_BLOCK_HEIGHT: bh_reg      <= cfg.data;
                pwt_pkg::REG_FRAME_WIDTH:  fw_reg      <= cfg.data;
                pwt_pkg::REG_FRAME_HEIGHT: fh_reg      <= cfg.data;
                pwt_pkg::REG_THR_ENABLE:   thr_en_reg  <= cfg.data[0];
                pwt_pkg::REG_THR_LEVEL:    thr_lvl_reg <= cfg.data[pwt_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // request side
    assign pix.ready = (state_reg == S_IDLE);
    assign pix_acc   = pix.valid && pix.ready;
    assign rd_start  = pix_acc && (pix.func == pwt_pkg::FUNC_READ);
    assign wr_ok     = (32'(pix.pos_x) < MAX_WIDTH) && (32'(pix.pos_y) < MAX_HEIGHT);
    assign mem_we    = pix_acc && (pix.func == pwt_pkg::FUNC_WRITE) && wr_ok;
    assign waddr     = AW'(32'(pix.pos_y) * 32'(MAX_WIDTH) + 32'(pix.pos_x));
    assign wdata     = {pix.alpha_in, pix.blue_in, pix.green_in, pix.red_in};

    always_ff @(posedge clk)
    begin
        if (rd_start)
        begin
            pos_x_reg <= pix.pos_x;
            pos_y_reg <= pix.pos_y;
        end
    end

    assign bw_eff = (bw_reg == '0) ? pwt_pkg::SIZE_W'(1) : bw_reg;
    assign bh_eff = (bh_reg == '0) ? pwt_pkg::SIZE_W'(1) : bh_reg;
    assign fw_eff = (fw_reg == '0) ? pwt_pkg::SIZE_W'(1) : fw_reg;
    assign fh_eff = (fh_reg == '0) ? pwt_pkg::SIZE_W'(1) : fh_reg;

    pwt_rem u_rem_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rd_start),
        .pos     (pix.pos_x),
        .divisor (bw_eff),
        .stat    (x_stat)
    );

    pwt_rem u_rem_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rd_start),
        .pos     (pix.pos_y),
        .divisor (bh_eff),
        .stat    (y_stat)
    );

    // sample point: origin + half block, clamped to the active frame
    assign x_org = pos_x_reg - pwt_pkg::POS_W'(x_stat.rem);
    assign y_org = pos_y_reg - pwt_pkg::POS_W'(y_stat.rem);
    assign x_smp = XCW'(x_org) + XCW'(bw_eff >> 1);
    assign y_smp = YCW'(y_org) + YCW'(bh_eff >> 1);
    assign x_fs  = (XCW'(fw_eff) > XCW'(MAX_WIDTH)) ? XCW'(MAX_WIDTH) : XCW'(fw_eff);
    assign y_fs  = (YCW'(fh_eff) > YCW'(MAX_HEIGHT)) ? YCW'(MAX_HEIGHT) : YCW'(fh_eff);
    assign x_lim = x_fs - 1'b1;
    assign y_lim = y_fs - 1'b1;
    assign x_cl  = (x_smp > x_lim) ? x_lim : x_smp;
    assign y_cl  = (y_smp > y_lim) ? y_lim : y_smp;

    always_comb
    begin
        sx_next = sx_reg;
        sy_next = sy_reg;
        if (state_reg == S_ADDR)
        begin
            sx_next = XW'(x_cl);
            sy_next = YW'(y_cl);
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        sy_reg <= sy_next;
    end

    assign raddr = AW'(32'(sy_reg) * 32'(MAX_WIDTH) + 32'(sx_reg));

    pwt_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (state_reg == S_READ),
        .raddr (raddr),
        .rdata (rdata)
    );

    // threshold and output register
    assign r_s   = rdata[pwt_pkg::CH_W-1:0];
    assign g_s   = rdata[2*pwt_pkg::CH_W-1:pwt_pkg::CH_W];
    assign b_s   = rdata[3*pwt_pkg::CH_W-1:2*pwt_pkg::CH_W];
    assign a_s   = rdata[4*pwt_pkg::CH_W-1:3*pwt_pkg::CH_W];
    assign br_rg = (g_s > r_s) ? g_s : r_s;
    assign br    = (b_s > br_rg) ? b_s : br_rg;
    assign dark  = thr_en_reg && (br < thr_lvl_reg);
    assign load  = (state_reg == S_RESULT) && (!res_valid_reg || res.ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= dark ? '0 : r_s;
            green_reg <= dark ? '0 : g_s;
            blue_reg  <= dark ? '0 : b_s;
            alpha_reg <= a_s;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.red_out   = red_reg;
    assign res.green_out = green_reg;
    assign res.blue_out  = blue_reg;
    assign res.alpha_out = alpha_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (rd_start) state_next = S_DIV;
            S_DIV:    if (!x_stat.busy) state_next = S_ADDR;
            S_ADDR:   state_next = S_READ;
            S_READ:   state_next = S_RESULT;
            S_RESULT: if (load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        x_stat.busy == y_stat.busy)
        else $error("remainder lanes out of step");

    a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        x_stat.busy |-> state_reg == S_DIV)
        else $error("remainder unit busy outside divide phase");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_RESULT)
        else $error("result raised without a completed read");
`endif

endmodule

`default_nettype wire
